// ----- rtl/wbc_pkg.sv -----
// Shared constants, payload types and codes of the word break checker.
package wbc_pkg;

  localparam int DICT_WORDS = 16;
  localparam int WORD_LEN   = 16;

  localparam int SYM_W  = 8;
  localparam int CNT_W  = $clog2(DICT_WORDS + 1);
  localparam int FILL_W = $clog2(WORD_LEN + 2);
  localparam int LEN_W  = $clog2(WORD_LEN + 1);
  localparam int POS_W  = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
  localparam int ROW_IW = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef sym_t [WORD_LEN-1:0] row_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ROW_IW-1:0] row_idx_t;

  typedef enum logic [1:0] {
    OP_WORD  = 2'd0,
    OP_KEY   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    sym_t       symbol;
    logic       last;
  } in_t;

  typedef struct packed {
    logic can_split;
    logic dict_overflow;
  } out_t;

  typedef struct packed {
    logic     char_we;
    logic     len_we;
    row_idx_t row;
    pos_t     lane;
    sym_t     data;
    len_t     len;
  } dict_wr_t;

endpackage

// ----- rtl/wbc_dict.sv -----
// Dictionary store: one row of characters and one length per word, registered read.
module wbc_dict (
  input  logic               clk,
  input  wbc_pkg::dict_wr_t  wr,
  input  wbc_pkg::row_idx_t  rd_addr,
  output wbc_pkg::row_t      row_out,
  output wbc_pkg::len_t      len_out
);

  wbc_pkg::row_t char_mem [wbc_pkg::DICT_WORDS];
  wbc_pkg::len_t len_mem  [wbc_pkg::DICT_WORDS];
  wbc_pkg::row_t row_r;
  wbc_pkg::len_t len_r;

  always_ff @(posedge clk) begin
    if (wr.char_we) begin
      char_mem[wr.row][wr.lane] <= wr.data;
    end
    if (wr.len_we) begin
      len_mem[wr.row] <= wr.len;
    end
    row_r <= char_mem[rd_addr];
    len_r <= len_mem[rd_addr];
  end

  assign row_out = row_r;
  assign len_out = len_r;

endmodule

// ----- rtl/wbc_cell.sv -----
// One window cell: a key history byte, a reach bit and its share of the word compare.
module wbc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wbc_pkg::pos_t      pos,
  input  logic               shift_en,
  input  logic               step_en,
  input  logic               clear_en,
  input  wbc_pkg::sym_t      sym_in,
  input  logic               reach_in,
  input  wbc_pkg::row_t      row,
  input  wbc_pkg::len_t      len,
  input  logic               all_in,
  input  logic               any_in,
  output wbc_pkg::sym_t      sym_out,
  output logic               reach_out,
  output logic               all_out,
  output logic               any_out
);

  localparam int LX_W = wbc_pkg::LEN_W + 1;

  wbc_pkg::sym_t hist_r;
  logic          reach_r;
  logic [LX_W-1:0] len_x;
  logic [LX_W-1:0] pos_x;
  logic [LX_W-1:0] idx_x;
  logic          in_word;
  logic          is_tail;
  wbc_pkg::sym_t word_sym;

  always_ff @(posedge clk) begin
    if (!rst_n || clear_en) begin
      hist_r  <= '0;
      reach_r <= (pos == '0);
    end else begin
      if (shift_en) begin
        hist_r <= sym_in;
      end
      if (step_en) begin
        reach_r <= reach_in;
      end
    end
  end

  // cell at pos compares against word character len-1-pos
  always_comb begin
    len_x    = LX_W'(len);
    pos_x    = LX_W'(pos);
    idx_x    = len_x - pos_x - LX_W'(1);
    in_word  = (pos_x < len_x);
    is_tail  = ((pos_x + LX_W'(1)) == len_x);
    word_sym = row[idx_x[wbc_pkg::POS_W-1:0]];
  end

  assign all_out   = all_in & (!in_word | (word_sym == hist_r));
  assign any_out   = any_in | (is_tail & reach_r);
  assign sym_out   = hist_r;
  assign reach_out = reach_r;

endmodule

// ----- rtl/word_break_checker.sv -----
// Word break checker: dictionary loader, scan sequencer and a row of window cells.
// Word character and clear transactions are taken without a stall.
// A key character stalls the input while every stored word is scanned: one stored
// word is read and compared per cycle through the single dictionary read port.
// A final key character's result enters the output register once that register is free.
// Synchronous active-low reset empties the dictionary, clears the window and drops any result.
module word_break_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wbc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output wbc_pkg::out_t  out_data
);

  localparam int WL = wbc_pkg::WORD_LEN;
  localparam int CW = wbc_pkg::CNT_W;
  localparam int FW = wbc_pkg::FILL_W;

  // Control registers and their next values
  wbc_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  wbc_pkg::row_idx_t scan_r, scan_nxt;
  logic              hit_r, hit_nxt;
  logic              dv_r, dv_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  wbc_pkg::out_t     out_r, out_nxt;

  // Strobes toward the dictionary and the cells
  wbc_pkg::dict_wr_t dwr;
  logic              key_shift;
  logic              win_step;
  logic              win_clear;
  logic              room;
  logic              chain_hit;

  wbc_pkg::row_t     rd_row;
  wbc_pkg::len_t     rd_len;

  wbc_pkg::sym_t     hist_c  [WL];
  logic              reach_c [WL];
  logic              all_c   [WL+1];
  logic              any_c   [WL+1];

  // Input is taken only between key scans; the output register decouples the result side.
  assign in_stall  = (state_r != wbc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Word character fits: inside the word bound and a free dictionary slot.
  assign room = (fill_r < FW'(WL)) && (cnt_r < CW'(wbc_pkg::DICT_WORDS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbc_pkg::ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      scan_r      <= '0;
      hit_r       <= 1'b0;
      dv_r        <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      scan_r      <= scan_nxt;
      hit_r       <= hit_nxt;
      dv_r        <= dv_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    scan_nxt      = scan_r;
    hit_nxt       = hit_r;
    last_nxt      = last_r;
    dv_nxt        = (state_r == wbc_pkg::ST_SCAN);
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    dwr           = '0;
    key_shift     = 1'b0;
    win_step      = 1'b0;
    win_clear     = 1'b0;

    dwr.row  = cnt_r[wbc_pkg::ROW_IW-1:0];
    dwr.lane = fill_r[wbc_pkg::POS_W-1:0];
    dwr.data = in_data.symbol;
    dwr.len  = wbc_pkg::LEN_W'(fill_r + FW'(1));

    unique case (state_r)
      wbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.operation)
            wbc_pkg::OP_WORD: begin
              dwr.char_we = room;
              if (in_data.last) begin
                // commit the word, or drop it and flag the loss
                if (room) begin
                  dwr.len_we = 1'b1;
                  cnt_nxt    = cnt_r + CW'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
                fill_nxt = '0;
              end else if (fill_r <= FW'(WL)) begin
                fill_nxt = fill_r + FW'(1);
              end
            end
            wbc_pkg::OP_CLEAR: begin
              cnt_nxt  = '0;
              fill_nxt = '0;
              ovf_nxt  = 1'b0;
            end
            wbc_pkg::OP_KEY: begin
              // shift the key byte into the history, then scan every stored word
              key_shift = 1'b1;
              last_nxt  = in_data.last;
              scan_nxt  = '0;
              hit_nxt   = 1'b0;
              state_nxt = (cnt_r == '0) ? wbc_pkg::ST_FIN : wbc_pkg::ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      wbc_pkg::ST_SCAN: begin
        // issue one dictionary read per cycle
        scan_nxt = scan_r + wbc_pkg::ROW_IW'(1);
        if (CW'(scan_r) == cnt_r - CW'(1)) begin
          state_nxt = wbc_pkg::ST_DRAIN;
        end
      end
      wbc_pkg::ST_DRAIN: begin
        // last read word is compared in this cycle
        state_nxt = wbc_pkg::ST_FIN;
      end
      wbc_pkg::ST_FIN: begin
        if (!last_r) begin
          win_step  = 1'b1;
          state_nxt = wbc_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          // report and reset the window for the next key
          win_clear             = 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.can_split     = hit_r;
          out_nxt.dict_overflow = ovf_r;
          state_nxt             = wbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wbc_pkg::ST_IDLE;
      end
    endcase

    // accumulate any word that ends the key history at a reachable prefix
    if (dv_r && chain_hit) begin
      hit_nxt = 1'b1;
    end
  end

  wbc_dict u_dict (
    .clk     (clk),
    .wr      (dwr),
    .rd_addr (scan_r),
    .row_out (rd_row),
    .len_out (rd_len)
  );

  // Compare chain: every cell checks its history byte against the read word, and the
  // cell at the word's start offers its reach bit.
  assign all_c[0] = 1'b1;
  assign any_c[0] = 1'b0;
  assign chain_hit = all_c[WL] & any_c[WL];

  for (genvar j = 0; j < WL; j++) begin : g_cell
    wbc_pkg::sym_t sym_in_w;
    logic          reach_in_w;

    if (j == 0) begin : g_head
      assign sym_in_w   = in_data.symbol;
      assign reach_in_w = hit_r;
    end else begin : g_body
      assign sym_in_w   = hist_c[j-1];
      assign reach_in_w = reach_c[j-1];
    end

    wbc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pos       (wbc_pkg::POS_W'(j)),
      .shift_en  (key_shift),
      .step_en   (win_step),
      .clear_en  (win_clear),
      .sym_in    (sym_in_w),
      .reach_in  (reach_in_w),
      .row       (rd_row),
      .len       (rd_len),
      .all_in    (all_c[j]),
      .any_in    (any_c[j]),
      .sym_out   (hist_c[j]),
      .reach_out (reach_c[j]),
      .all_out   (all_c[j+1]),
      .any_out   (any_c[j+1])
    );
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(wbc_pkg::DICT_WORDS))
    else $error("word count beyond dictionary size");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WL + 1))
    else $error("fill length beyond saturation");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wbc_pkg::ST_SCAN |-> (cnt_r != '0 && CW'(scan_r) < cnt_r))
    else $error("scan address outside committed words");

  a_compare_window: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == wbc_pkg::ST_SCAN || state_r == wbc_pkg::ST_DRAIN))
    else $error("compare data valid outside a scan");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wbc_pkg::ST_FIN && last_r && !(out_valid_r && out_stall))
      |=> out_valid_r && state_r == wbc_pkg::ST_IDLE)
    else $error("final key character left no result");

endmodule

// ----- test/wbc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the word break checker: predicts each key verdict and compares it.
module wbc_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  wbc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  wbc_pkg::out_t out_data,
  output int            fail_count,
  output int            backlog
);

  // Shadow copy of the dictionary and of the sliding key window.
  wbc_pkg::sym_t              dict_sym [wbc_pkg::DICT_WORDS][wbc_pkg::WORD_LEN];
  wbc_pkg::len_t              dict_len [wbc_pkg::DICT_WORDS];
  logic [wbc_pkg::CNT_W-1:0]  n_words;
  logic [wbc_pkg::FILL_W-1:0] fill;
  logic                       sticky_drop;
  wbc_pkg::sym_t              recent [wbc_pkg::WORD_LEN];
  logic [wbc_pkg::WORD_LEN:0] reach_bits;

  wbc_pkg::out_t verdict_q[$];
  int            errors = 0;

  assign fail_count = errors;

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%0t wbc_checker: %s", $time, msg);
  endtask

  task automatic restart_window();
    for (int i = 0; i < wbc_pkg::WORD_LEN; i++) recent[i] = '0;
    reach_bits = '0;
    reach_bits[0] = 1'b1;
  endtask

  // A word ends at the newest key character when the prefix just before it is reachable.
  function automatic logic word_hits(input int w);
    int len;
    len = int'(dict_len[w]);
    if (len < 1 || len > wbc_pkg::WORD_LEN || !reach_bits[len-1]) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (dict_sym[w][i] != recent[len-1-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_item(input wbc_pkg::in_t item);
    logic hit;
    hit = 1'b0;
    case (item.operation)
      wbc_pkg::OP_WORD: begin
        if (int'(fill) < wbc_pkg::WORD_LEN && int'(n_words) < wbc_pkg::DICT_WORDS)
          dict_sym[int'(n_words)][int'(fill)] = item.symbol;
        if (int'(fill) <= wbc_pkg::WORD_LEN) fill = fill + 1'b1;
        if (item.last) begin
          if (int'(fill) <= wbc_pkg::WORD_LEN && int'(n_words) < wbc_pkg::DICT_WORDS) begin
            dict_len[int'(n_words)] = wbc_pkg::len_t'(fill);
            n_words = n_words + 1'b1;
          end else begin
            sticky_drop = 1'b1;
          end
          fill = '0;
        end
      end
      wbc_pkg::OP_CLEAR: begin
        // Window survives a clear; only the dictionary and its overflow flag go.
        n_words     = '0;
        fill        = '0;
        sticky_drop = 1'b0;
      end
      wbc_pkg::OP_KEY: begin
        for (int i = wbc_pkg::WORD_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = item.symbol;
        for (int w = 0; w < int'(n_words) && w < wbc_pkg::DICT_WORDS; w++) begin
          if (word_hits(w)) hit = 1'b1;
        end
        reach_bits = {reach_bits[wbc_pkg::WORD_LEN-1:0], hit};
        if (item.last) begin
          verdict_q.push_back('{can_split: hit, dict_overflow: sticky_drop});
          restart_window();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    wbc_pkg::out_t want;
    if (!rst_n) begin
      n_words     = '0;
      fill        = '0;
      sticky_drop = 1'b0;
      restart_window();
      verdict_q.delete();
    end else begin
      // Check the output first: a result never leaves on the edge its key enters.
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          flag($sformatf("unexpected result can_split=%0b dict_overflow=%0b",
                         out_data.can_split, out_data.dict_overflow));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.can_split !== want.can_split)
            flag($sformatf("can_split expected %0b got %0b",
                           want.can_split, out_data.can_split));
          if (out_data.dict_overflow !== want.dict_overflow)
            flag($sformatf("dict_overflow expected %0b got %0b",
                           want.dict_overflow, out_data.dict_overflow));
        end
      end
      if (in_valid && !in_stall) absorb_item(in_data);
    end
    backlog <= verdict_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the word break checker, with the scoreboard beside the block.
module testbench;

  // Operation code the block must ignore.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 3000;
  localparam int         ITEM_GOAL   = 500;
  localparam int         KEY_MAX     = 64;
  localparam int         LIB_MAX     = 20;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  wbc_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  wbc_pkg::out_t out_data;

  int fail_count;
  int backlog;
  int items_sent = 0;
  bit calm       = 1'b0;   // when set, both sides run without gaps

  word_break_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  wbc_checker verdict_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one transaction and hold it until the block takes it. Valid stays high
  // into the next transaction when no gap follows, so it is never dropped and
  // raised in the same step.
  task automatic push_item(input logic [1:0] op, input wbc_pkg::sym_t sym, input logic fin);
    int gap;
    in_data  <= '{operation: op, symbol: sym, last: fin};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED) items_sent++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every pending verdict has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  // Stall the result channel at random.
  initial begin : sink_pacing
    int hold;
    forever begin
      @(posedge clk);
      hold = calm ? 0 : idle_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // End the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    wbc_pkg::sym_t alpha [3];
    wbc_pkg::sym_t lib_chars [LIB_MAX][LIB_MAX];
    int            lib_len [LIB_MAX];
    wbc_pkg::sym_t key_buf [KEY_MAX];
    int            lib_n, nw, len, nk, np, klen, w, c, k, p;
    bit            first;
    wbc_pkg::sym_t ch;
    logic [1:0]    noise_op;

    lib_n = 0;
    first = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    push_item(wbc_pkg::OP_KEY, 8'h00, 1'b1);      // empty dictionary: no split
    push_item(wbc_pkg::OP_WORD, 8'h00, 1'b1);     // one-character word, lowest symbol
    push_item(wbc_pkg::OP_WORD, 8'hFF, 1'b0);     // two-character word with highest symbol
    push_item(wbc_pkg::OP_WORD, 8'h01, 1'b1);
    push_item(wbc_pkg::OP_KEY, 8'h00, 1'b0);      // 00 | FF 01 splits
    push_item(wbc_pkg::OP_KEY, 8'hFF, 1'b0);
    push_item(wbc_pkg::OP_KEY, 8'h01, 1'b1);
    push_item(wbc_pkg::OP_KEY, 8'hFF, 1'b1);      // half a word: no split
    push_item(OP_UNUSED, 8'hAA, 1'b1);            // ignored code
    push_item(wbc_pkg::OP_KEY, 8'h00, 1'b0);      // clear in the middle of a key keeps the window
    push_item(wbc_pkg::OP_CLEAR, 8'h5A, 1'b1);
    push_item(wbc_pkg::OP_KEY, 8'h00, 1'b1);
    push_item(wbc_pkg::OP_WORD, 8'h80, 1'b1);
    push_item(wbc_pkg::OP_WORD, 8'h80, 1'b1);     // duplicate word
    push_item(wbc_pkg::OP_KEY, 8'h80, 1'b1);

    // Random part: load a dictionary, then mostly keys built from its words.
    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 5) == 0);
      if (first || $urandom_range(0, 5) == 0) wait_for_drain();

      if (first || lib_n == 0 || $urandom_range(0, 2) == 0) begin
        push_item(wbc_pkg::OP_CLEAR, wbc_pkg::sym_t'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        for (int a = 0; a < 3; a++) alpha[a] = wbc_pkg::sym_t'($urandom_range(0, 255));
        // The first dictionary overfills and holds a full-length and a too-long word.
        if (first) nw = wbc_pkg::DICT_WORDS + 1;
        else if ($urandom_range(0, 7) == 0)
          nw = $urandom_range(wbc_pkg::DICT_WORDS - 1, wbc_pkg::DICT_WORDS + 3);
        else nw = $urandom_range(1, 6);
        lib_n = 0;
        for (w = 0; w < nw; w++) begin
          if (first && w < 2) len = wbc_pkg::WORD_LEN + w;
          else if ($urandom_range(0, 11) == 0)
            len = $urandom_range(wbc_pkg::WORD_LEN - 1, wbc_pkg::WORD_LEN + 3);
          else len = $urandom_range(1, 4);
          for (c = 0; c < len; c++) begin
            ch = alpha[$urandom_range(0, 2)];
            lib_chars[w][c] = ch;
            push_item(wbc_pkg::OP_WORD, ch, c == len - 1);
          end
          lib_len[w] = len;
          lib_n++;
        end
        first = 1'b0;
      end

      nk = $urandom_range(1, 5);
      for (k = 0; k < nk && lib_n > 0; k++) begin
        klen = 0;
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        for (p = 0; p < np; p++) begin
          if ($urandom_range(0, 5) == 0) begin
            // stray character breaks most splits
            if (klen < KEY_MAX) begin
              key_buf[klen] = alpha[$urandom_range(0, 2)];
              klen++;
            end
          end else begin
            w = $urandom_range(0, lib_n - 1);
            for (c = 0; c < lib_len[w] && klen < KEY_MAX; c++) begin
              key_buf[klen] = lib_chars[w][c];
              klen++;
            end
          end
        end
        for (c = 0; c < klen; c++) begin
          if ($urandom_range(0, 59) == 0) begin
            push_item(wbc_pkg::OP_CLEAR, wbc_pkg::sym_t'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            lib_n = 0;
          end
          if ($urandom_range(0, 39) == 0)
            push_item(OP_UNUSED, wbc_pkg::sym_t'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          push_item(wbc_pkg::OP_KEY, key_buf[c], c == klen - 1);
        end
      end

      // Occasional fully random transaction.
      if ($urandom_range(0, 3) == 0) begin
        noise_op = 2'($urandom_range(0, 3));
        push_item(noise_op, wbc_pkg::sym_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (noise_op == wbc_pkg::OP_CLEAR) lib_n = 0;
      end
    end

    // Drain, then give the block time to show any stray result.
    calm = 1'b0;
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wbc_pkg.sv
rtl/wbc_dict.sv
rtl/wbc_cell.sv
rtl/word_break_checker.sv
test/wbc_checker.sv
test/testbench.sv
